// ----- hdl/dvh_pkg.sv -----
// ----------------------------------------------------------------------------
// dvh_pkg
// Shared types and constants for the distinct value hit table.
// ----------------------------------------------------------------------------
package dvh_pkg;

  localparam int VALUE_W      = 64;
  localparam int HITS_W       = 32;
  localparam int READ_INDEX_W = 4;
  localparam int SLOT_W       = 4;
  localparam int FILL_W       = 5;

  localparam logic FUNC_NOTE = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  // one table entry as held in the RAM
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [HITS_W-1:0]  hits;
  } entry_t;

  // one result transaction
  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic [VALUE_W-1:0] stored_value;
    logic [HITS_W-1:0]  hit_count;
    logic               was_new;
    logic               dropped;
    logic               entry_valid;
    logic [FILL_W-1:0]  fill_count;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RDREQ,
    ST_RDDAT,
    ST_DONE
  } state_t;

endpackage

// ----- hdl/dvh_ram.sv -----
// ----------------------------------------------------------------------------
// dvh_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dvh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/dvh_ctrl.sv -----
// ----------------------------------------------------------------------------
// dvh_ctrl
// Sequencer: scans the table RAM one slot a cycle for a note and updates,
// appends or drops; serves reads; and builds the result transaction.
// ----------------------------------------------------------------------------
module dvh_ctrl import dvh_pkg::*; #(
  parameter int TABLE_SLOTS = 16,
  parameter int IDX_W       = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_valid,
  output logic                    s_ready,
  input  logic                    func,
  input  logic [VALUE_W-1:0]      value,
  input  logic [READ_INDEX_W-1:0] read_index,
  output logic                    res_valid,
  input  logic                    res_take,
  output result_t                 res,
  output logic                    ram_we,
  output logic [IDX_W-1:0]        ram_waddr,
  output entry_t                  ram_wdata,
  output logic                    ram_re,
  output logic [IDX_W-1:0]        ram_raddr,
  input  entry_t                  ram_rdata
);

  localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
  localparam int CMP_W = (CNT_W > READ_INDEX_W) ? CNT_W : READ_INDEX_W;

  state_t                  state, state_next;
  logic [VALUE_W-1:0]      value_r;
  logic [READ_INDEX_W-1:0] ridx_r;
  logic [CNT_W-1:0]        fill;
  logic [CNT_W-1:0]        rd_ptr;
  logic                    cmp_vld;
  logic [IDX_W-1:0]        cmp_idx;
  result_t                 res_next;
  logic                    res_load;
  logic                    fill_inc;

  logic              hit, scan_end, full, rd_in_range;
  logic [HITS_W-1:0] hits_inc;

  // compare acts in the cycle after the read address (registered RAM read data)
  assign hit         = cmp_vld && (ram_rdata.value == value_r);
  assign scan_end    = (rd_ptr >= fill);
  assign full        = (fill == CNT_W'(TABLE_SLOTS));
  assign rd_in_range = (CMP_W'(ridx_r) < CMP_W'(fill));
  assign hits_inc    = (ram_rdata.hits == '1) ? ram_rdata.hits
                                              : ram_rdata.hits + HITS_W'(1);

  assign s_ready   = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_valid) begin
          state_next = (func == FUNC_READ) ? ST_RDREQ : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit || scan_end) begin
          state_next = ST_DONE;
        end
      end
      ST_RDREQ: begin
        state_next = rd_in_range ? ST_RDDAT : ST_DONE;
      end
      ST_RDDAT: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (res_take) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ram_re          = 1'b0;
    ram_raddr       = rd_ptr[IDX_W-1:0];
    ram_we          = 1'b0;
    ram_waddr       = cmp_idx;
    ram_wdata.value = value_r;
    ram_wdata.hits  = hits_inc;
    res_load        = 1'b0;
    res_next        = '0;
    fill_inc        = 1'b0;
    case (state)
      ST_SCAN: begin
        if (hit) begin
          ram_we                = 1'b1;
          res_load              = 1'b1;
          res_next.slot         = SLOT_W'(cmp_idx);
          res_next.stored_value = ram_rdata.value;
          res_next.hit_count    = hits_inc;
          res_next.entry_valid  = 1'b1;
          res_next.fill_count   = FILL_W'(fill);
        end else if (!scan_end) begin
          ram_re = 1'b1;
        end else if (full) begin
          res_load            = 1'b1;
          res_next.dropped    = 1'b1;
          res_next.fill_count = FILL_W'(fill);
        end else begin
          // append in the next free slot
          ram_we                = 1'b1;
          ram_waddr             = fill[IDX_W-1:0];
          ram_wdata.hits        = HITS_W'(1);
          fill_inc              = 1'b1;
          res_load              = 1'b1;
          res_next.slot         = SLOT_W'(fill);
          res_next.stored_value = value_r;
          res_next.hit_count    = HITS_W'(1);
          res_next.was_new      = 1'b1;
          res_next.entry_valid  = 1'b1;
          res_next.fill_count   = FILL_W'(fill + CNT_W'(1));
        end
      end
      ST_RDREQ: begin
        if (rd_in_range) begin
          ram_re    = 1'b1;
          ram_raddr = IDX_W'(ridx_r);
        end else begin
          res_load            = 1'b1;
          res_next.slot       = SLOT_W'(ridx_r);
          res_next.fill_count = FILL_W'(fill);
        end
      end
      ST_RDDAT: begin
        res_load              = 1'b1;
        res_next.slot         = SLOT_W'(ridx_r);
        res_next.stored_value = ram_rdata.value;
        res_next.hit_count    = ram_rdata.hits;
        res_next.entry_valid  = 1'b1;
        res_next.fill_count   = FILL_W'(fill);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      fill    <= '0;
      cmp_vld <= 1'b0;
    end else begin
      state <= state_next;
      if (fill_inc) begin
        fill <= fill + CNT_W'(1);
      end
      if (state == ST_SCAN) begin
        cmp_vld <= ram_re;
      end else begin
        cmp_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      value_r <= value;
      ridx_r  <= read_index;
      rd_ptr  <= '0;
    end else if (state == ST_SCAN && ram_re) begin
      rd_ptr  <= rd_ptr + CNT_W'(1);
      cmp_idx <= rd_ptr[IDX_W-1:0];
    end
    if (res_load) begin
      res <= res_next;
    end
  end

endmodule

// ----- hdl/distinct_value_hit_table.sv -----
// ----------------------------------------------------------------------------
// distinct_value_hit_table
// Table of distinct 64-bit values with saturating 32-bit hit counters.
// ----------------------------------------------------------------------------
// A note transaction searches the filled slots in order, lowest first, one
// RAM read per cycle; on a match it bumps that slot's counter (saturating),
// otherwise it appends the value with a count of one, or reports a drop when
// all TABLE_SLOTS slots are in use. A read transaction returns the entry at
// read_index, marked invalid at or beyond the fill count. One item is worked
// at a time: a note's search runs slot by slot, paced by the single read port
// of the entry RAM and its registered read data. The result sits in an output
// register, so the next item is accepted while an earlier result waits for
// m_axis_tready.
module distinct_value_hit_table import dvh_pkg::*; #(
  parameter int TABLE_SLOTS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [71:0]  s_axis_tdata,   // value[63:0], read_index[67:64], zero
  input  logic         s_axis_tuser,   // func
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // slot[3:0], stored_value[67:4], hit_count[99:68], fill_count[104:100], zero
  output logic [111:0] m_axis_tdata,
  output logic [2:0]   m_axis_tuser    // was_new, dropped, entry_valid
);

  localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  entry_t           ram_wdata, ram_rdata;
  logic             res_valid, res_take;
  result_t          res;
  logic             out_full;
  result_t          out_res;

  dvh_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  dvh_ctrl #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .s_valid    (s_axis_tvalid),
    .s_ready    (s_axis_tready),
    .func       (s_axis_tuser),
    .value      (s_axis_tdata[63:0]),
    .read_index (s_axis_tdata[67:64]),
    .res_valid  (res_valid),
    .res_take   (res_take),
    .res        (res),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata)
  );

  assign res_take = !out_full || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (res_valid && res_take) begin
      out_full <= 1'b1;
    end else if (m_axis_tready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_full;
  assign m_axis_tdata  = {7'd0, out_res.fill_count, out_res.hit_count,
                          out_res.stored_value, out_res.slot};
  assign m_axis_tuser  = {out_res.entry_valid, out_res.dropped, out_res.was_new};

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (int'(m_axis_tdata[104:100]) <= TABLE_SLOTS))
    else $error("fill count beyond table size");

  a_new_xor_drop: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("result both new and dropped");

  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[1]) |->
      (!m_axis_tuser[2] && int'(m_axis_tdata[104:100]) == TABLE_SLOTS))
    else $error("drop reported with room left or valid entry");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second transaction accepted while busy");

endmodule

// ----- dv/tb_distinct_value_hit_table.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_distinct_value_hit_table
// Self-checking bench for the distinct value hit table. A short directed
// table fills the table to capacity and covers empty reads, append, hit,
// drop and out-of-range reads. A random phase then mixes hits on stored
// values, near misses, fresh values and reads. Every result is checked, with
// random stalls on both streams, against a table model or a fixed result.
// ----------------------------------------------------------------------------
module tb_distinct_value_hit_table;
  import dvh_pkg::*;

  localparam int SLOTS        = 16;
  localparam int RANDOM_ITEMS = 950;
  localparam int DRAIN_CYCLES = 25;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int IDLE_PCT     = 27;

  typedef struct {
    logic                    func;
    logic [VALUE_W-1:0]      value;
    logic [READ_INDEX_W-1:0] index;
    bit                      typed;
    result_t                 want;
  } stim_row_t;

  localparam result_t NO_WANT = '0;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [71:0]  s_axis_tdata = '0;   // value[63:0], read_index[67:64], zero
  logic         s_axis_tuser = 1'b0; // func
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // slot[3:0], stored_value[67:4], hit_count[99:68], fill_count[104:100], zero
  logic [111:0] m_axis_tdata;
  logic [2:0]   m_axis_tuser;        // was_new, dropped, entry_valid

  distinct_value_hit_table #(.TABLE_SLOTS(SLOTS)) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // local copy of the table contents
  logic [VALUE_W-1:0] seen_values [SLOTS];
  logic [HITS_W-1:0]  seen_hits   [SLOTS];
  int                 seen_fill;

  result_t pending_results[$];
  bit      failed  = 1'b0;
  bit      idle_on = 1'b1;
  int      cycles  = 0;

  stim_row_t directed [25] = '{
    '{FUNC_READ, 64'h0, 4'd0,  1'b1, '{4'd0, 64'h0, 32'd0, 1'b0, 1'b0, 1'b0, 5'd0}},
    '{FUNC_READ, 64'h0, 4'd15, 1'b1, '{4'd15, 64'h0, 32'd0, 1'b0, 1'b0, 1'b0, 5'd0}},
    '{FUNC_NOTE, 64'h0, 4'd0,  1'b1, '{4'd0, 64'h0, 32'd1, 1'b1, 1'b0, 1'b1, 5'd1}},
    '{FUNC_NOTE, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b1,
      '{4'd1, 64'hFFFF_FFFF_FFFF_FFFF, 32'd1, 1'b1, 1'b0, 1'b1, 5'd2}},
    '{FUNC_NOTE, 64'h0, 4'd0, 1'b0, NO_WANT},
    '{FUNC_READ, 64'h0, 4'd0, 1'b0, NO_WANT},
    '{FUNC_READ, 64'h0, 4'd1, 1'b0, NO_WANT},
    '{FUNC_READ, 64'h0, 4'd2, 1'b0, NO_WANT},
    '{FUNC_NOTE, 64'h8000_0000_0000_0000, 4'd0, 1'b0, NO_WANT},
    '{FUNC_NOTE, 64'h0000_0000_0000_0001, 4'd0, 1'b0, NO_WANT},
    '{FUNC_NOTE, 64'hAAAA_AAAA_AAAA_AAAA, 4'd0, 1'b0, NO_WANT},
    '{FUNC_NOTE, 64'h5555_5555_5555_5555, 4'd0, 1'b0, NO_WANT},
    '{FUNC_NOTE, 64'h0123_4567_89AB_CDEF, 4'd0, 1'b0, NO_WANT},
    '{FUNC_NOTE, 64'hFEDC_BA98_7654_3210, 4'd0, 1'b0, NO_WANT},
    '{FUNC_NOTE, 64'h0000_0000_FFFF_FFFF, 4'd0, 1'b0, NO_WANT},
    '{FUNC_NOTE, 64'hFFFF_FFFF_0000_0000, 4'd0, 1'b0, NO_WANT},
    '{FUNC_NOTE, 64'h7FFF_FFFF_FFFF_FFFF, 4'd0, 1'b0, NO_WANT},
    '{FUNC_NOTE, 64'h0000_0001_0000_0000, 4'd0, 1'b0, NO_WANT},
    '{FUNC_NOTE, 64'hC3C3_C3C3_C3C3_C3C3, 4'd0, 1'b0, NO_WANT},
    '{FUNC_NOTE, 64'h3C3C_3C3C_3C3C_3C3C, 4'd0, 1'b0, NO_WANT},
    '{FUNC_NOTE, 64'h0F0F_0F0F_0F0F_0F0F, 4'd0, 1'b0, NO_WANT},
    '{FUNC_NOTE, 64'hF0F0_F0F0_F0F0_F0F0, 4'd0, 1'b0, NO_WANT},
    // table is full now: a fresh value is dropped
    '{FUNC_NOTE, 64'hFFFF_FFFF_FFFF_FFFE, 4'd0, 1'b1,
      '{4'd0, 64'h0, 32'd0, 1'b0, 1'b1, 1'b0, 5'd16}},
    '{FUNC_READ, 64'h0, 4'd15, 1'b0, NO_WANT},
    '{FUNC_NOTE, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b0, NO_WANT}
  };

  // Applies one transaction to the local table and returns its result.
  function automatic result_t tally_item(logic func, logic [VALUE_W-1:0] value,
                                         logic [READ_INDEX_W-1:0] index);
    result_t r;
    r = '0;
    if (func == FUNC_READ) begin
      r.slot = index;
      if (int'(index) < seen_fill) begin
        r.stored_value = seen_values[index];
        r.hit_count    = seen_hits[index];
        r.entry_valid  = 1'b1;
      end
      r.fill_count = FILL_W'(seen_fill);
      return r;
    end
    for (int i = 0; i < seen_fill; i++) begin
      if (seen_values[i] == value) begin
        if (seen_hits[i] != '1) seen_hits[i] = seen_hits[i] + 1'b1;
        r.slot         = SLOT_W'(i);
        r.stored_value = seen_values[i];
        r.hit_count    = seen_hits[i];
        r.entry_valid  = 1'b1;
        r.fill_count   = FILL_W'(seen_fill);
        return r;
      end
    end
    if (seen_fill >= SLOTS) begin
      r.dropped    = 1'b1;
      r.fill_count = FILL_W'(seen_fill);
      return r;
    end
    seen_values[seen_fill] = value;
    seen_hits[seen_fill]   = 1;
    r.slot         = SLOT_W'(seen_fill);
    r.stored_value = value;
    r.hit_count    = 1;
    r.was_new      = 1'b1;
    r.entry_valid  = 1'b1;
    seen_fill      = seen_fill + 1;
    r.fill_count   = FILL_W'(seen_fill);
    return r;
  endfunction

  // Drives one transaction and returns once it has been accepted.
  task automatic drive_item(logic func, logic [VALUE_W-1:0] value,
                            logic [READ_INDEX_W-1:0] index,
                            bit typed, result_t want);
    result_t predicted;
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, index, value};
    s_axis_tuser  <= func;
    do @(posedge clk); while (!s_axis_tready);
    predicted = tally_item(func, value, index);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      failed = 1'b1;
    end
  endtask

  // result side: compare each transaction, then pick next ready
  always @(posedge clk) begin
    result_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction: tdata %h tuser %h",
               m_axis_tdata, m_axis_tuser);
        failed = 1'b1;
      end else begin
        want = pending_results.pop_front();
        check_field("slot",         64'(want.slot),        64'(m_axis_tdata[3:0]));
        check_field("stored_value", want.stored_value,     m_axis_tdata[67:4]);
        check_field("hit_count",    64'(want.hit_count),   64'(m_axis_tdata[99:68]));
        check_field("fill_count",   64'(want.fill_count),  64'(m_axis_tdata[104:100]));
        check_field("was_new",      64'(want.was_new),     64'(m_axis_tuser[0]));
        check_field("dropped",      64'(want.dropped),     64'(m_axis_tuser[1]));
        check_field("entry_valid",  64'(want.entry_valid), 64'(m_axis_tuser[2]));
      end
    end
    m_axis_tready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int                      pick;
    logic                    func;
    logic [VALUE_W-1:0]      value;
    logic [READ_INDEX_W-1:0] index;
    seen_fill = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[k])
      drive_item(directed[k].func, directed[k].value, directed[k].index,
                 directed[k].typed, directed[k].want);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // quiet stretch in the middle: no gaps on either stream
      idle_on = !(n >= 350 && n < 600);
      pick  = $urandom_range(99);
      value = {$urandom, $urandom};
      index = READ_INDEX_W'($urandom_range(SLOTS - 1));
      if (pick < 30) begin
        func = FUNC_READ;
      end else begin
        func = FUNC_NOTE;
        if (pick < 75) begin
          value = seen_values[$urandom_range(seen_fill - 1)];
        end else if (pick < 87) begin
          // near miss: stored value with a single bit flipped
          value = seen_values[$urandom_range(seen_fill - 1)];
          value[$urandom_range(VALUE_W - 1)] ^= 1'b1;
        end
      end
      drive_item(func, value, index, 1'b0, NO_WANT);
    end
    s_axis_tvalid <= 1'b0;
    idle_on = 1'b1;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/dvh_pkg.sv
hdl/dvh_ram.sv
hdl/dvh_ctrl.sv
hdl/distinct_value_hit_table.sv
dv/tb_distinct_value_hit_table.sv
